### hw/rtl/archive_block_header_walker_assert.svh
// assertion macros for the archive block header walker
`ifndef ARCHIVE_BLOCK_HEADER_WALKER_ASSERT_SVH
`define ARCHIVE_BLOCK_HEADER_WALKER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define ABHW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define ABHW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/abhw_pkg.sv
`default_nettype none
package abhw_pkg;
  localparam int PosBits = 40;

  typedef enum logic [5:0] {
    PH_ARCH    = 6'b000001,
    PH_PREFIX  = 6'b000010,
    PH_NAME    = 6'b000100,
    PH_TAIL    = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_ERROR   = 6'b100000
  } phase_t;

  localparam logic [3:0] ERR_OK = 4'd0;
  localparam logic [3:0] ERR_ARCH = 4'd1;
  localparam logic [3:0] ERR_VOLUME = 4'd2;
  localparam logic [3:0] ERR_BLOCK = 4'd3;
  localparam logic [3:0] ERR_HEADER = 4'd4;
  localparam logic [3:0] ERR_NAME = 4'd5;
  localparam logic [3:0] ERR_SIZES = 4'd6;
  localparam logic [3:0] ERR_TRUNC = 4'd7;
  localparam logic [3:0] ERR_COUNT = 4'd8;
  localparam logic [3:0] ERR_CRC = 4'd9;
  localparam logic [3:0] ERR_EMPTY = 4'd10;

  localparam logic [31:0] CrcPoly = 32'hedb88320;
  localparam logic [19:0] MemberLimitReset = 20'd200000;
  localparam logic [31:0] CrcLimitReset = 32'h0010_0000;

  localparam logic [0:0] REG_MEMBER_LIMIT = 1'b0;
  localparam logic [0:0] REG_CRC_LIMIT = 1'b1;

  // record layout, tdata packed from bit 0 up
  localparam int RecBits = 1 + PosBits + 32 + 8 + 32 * 4 + 4 + 20 + 2 + 16;
  localparam int RecBytes = (RecBits + 7) / 8;

  typedef struct packed {
    logic [15:0]        disk_number;
    logic [1:0]         volume_kind;
    logic [19:0]        member_count;
    logic [3:0]         error_code;
    logic [31:0]        packed_crc;
    logic [31:0]        dos_stamp;
    logic [31:0]        attributes;
    logic [31:0]        unpacked_size;
    logic [7:0]         member_flags;
    logic [31:0]        data_size;
    logic [PosBits-1:0] position;
    logic               record_kind;
  } rec_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = (r >> 1) ^ (r[0] ? CrcPoly : 32'd0);
    return r;
  endfunction

  function automatic logic [1:0] vol_kind(input logic [31:0] v);
    logic [1:0] k;
    k = 2'd0;
    if (v == 32'd2) k = 2'd1;
    if (v == 32'd4) k = 2'd2;
    if (v == 32'd8) k = 2'd3;
    return k;
  endfunction

  function automatic logic flags_ok(input logic [31:0] f);
    logic [31:0] m;
    logic [31:0] s;
    m = f & 32'h30;
    s = f & 32'h0b;
    return ((f & ~32'h3b) == 32'd0) && (m == 32'h10 || m == 32'h20)
      && (s == 32'h01 || s == 32'h02 || s == 32'h08);
  endfunction
endpackage
`default_nettype wire

### hw/rtl/archive_block_header_walker.sv
`default_nettype none
// Archive block header walker. One file byte enters per transaction on
// s_axis (tdata = data_byte, tlast = last of file) and the block takes a new
// byte every clock cycle while its four-entry result queue holds at most two
// records; each byte is judged by one registered step (counters, compares,
// one byte of CRC-32), and its records are offered on m_axis from the registered
// result queue, in order. A member record leaves on m_axis after the last header
// word of each accepted member, and a verdict after every last byte; tuser is
// record_kind (1 = verdict). After the verdict the walk restarts for the next
// file; the two limit registers are kept. Registers are written on the cfg
// channel: index 0 member_limit, index 1 crc_size_limit.
module archive_block_header_walker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tlast,   // last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // position, data_size, member_flags, unpacked_size, attributes, dos_stamp,
  // packed_crc, error_code, member_count, volume_kind, disk_number
  output logic [8*((abhw_pkg::RecBits-1+7)/8)-1:0] m_axis_tdata,
  output logic             m_axis_tuser,   // record_kind
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int DataBits = abhw_pkg::RecBits - 1;
  localparam int DataPad = 8 * ((DataBits + 7) / 8);

  logic [19:0] member_limit;
  logic [31:0] crc_size_limit;
  logic in_fire;
  logic room;
  abhw_pkg::rec_t head;

  // walk state
  abhw_pkg::phase_t phase;
  logic [4:0]  sect;
  logic [abhw_pkg::PosBits-1:0] byte_pos;
  logic [abhw_pkg::PosBits-1:0] block_start;
  logic [31:0] hw [10];
  logic [7:0]  name_left;
  logic [31:0] pay_left;
  logic [19:0] members;
  logic [31:0] crc;
  logic [1:0]  crc_status;
  logic [3:0]  first_err;
  logic [31:0] crc_exp;

  logic push_a, push_b;
  abhw_pkg::rec_t rec_a, rec_b;

  assign cfg_ready = 1'b1;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = room;
  assign m_axis_tuser = head.record_kind;
  assign m_axis_tdata = DataPad'(head[abhw_pkg::RecBits-1:1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      member_limit <= abhw_pkg::MemberLimitReset;
      crc_size_limit <= abhw_pkg::CrcLimitReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        abhw_pkg::REG_MEMBER_LIMIT: member_limit <= cfg_data[19:0];
        abhw_pkg::REG_CRC_LIMIT:    crc_size_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // next-state values
  abhw_pkg::phase_t phase_next;
  logic [4:0]  sect_next;
  logic [31:0] hw_next [10];
  logic [7:0]  name_next;
  logic [31:0] pay_next;
  logic [19:0] members_next;
  logic [31:0] crc_next;
  logic [1:0]  cst_next;
  logic [3:0]  err_next;
  logic [31:0] exp_next;
  logic [abhw_pkg::PosBits-1:0] bstart_next;
  logic [abhw_pkg::PosBits-1:0] pos_inc;
  logic [7:0]  b;
  logic [31:0] fl, dsz;
  logic        split;
  logic [3:0]  verr;

  always_comb begin
    b = s_axis_tdata;
    pos_inc = byte_pos + 1'b1;
    phase_next = phase;
    sect_next = sect;
    for (int w = 0; w < 10; w++) hw_next[w] = hw[w];
    name_next = name_left;
    pay_next = pay_left;
    members_next = members;
    crc_next = crc;
    cst_next = crc_status;
    err_next = first_err;
    exp_next = crc_exp;
    bstart_next = block_start;
    push_a = 1'b0;
    fl = '0;
    dsz = '0;
    split = 1'b0;
    unique case (phase)
      abhw_pkg::PH_ARCH: begin
        if (sect < 5'd8) begin
          logic [7:0] lead;
          lead = 8'h00;
          unique case (sect[2:0])
            3'd0: lead = 8'h41;
            3'd1: lead = 8'h52;
            3'd2: lead = 8'h43;
            3'd3: lead = 8'h56;
            3'd4: lead = 8'h00;
            3'd5: lead = 8'h02;
            3'd6: lead = 8'h0e;
            default: lead = 8'h00;
          endcase
          if (b != lead) begin
            if (err_next == abhw_pkg::ERR_OK) err_next = abhw_pkg::ERR_ARCH;
            phase_next = abhw_pkg::PH_ERROR;
          end
        end else if (sect < 5'd12) begin
          hw_next[0][sect[1:0]*8 +: 8] = b;
          if (sect == 5'd11 && hw_next[0] != 32'd1
              && abhw_pkg::vol_kind(hw_next[0]) == 2'd0) begin
            if (err_next == abhw_pkg::ERR_OK) err_next = abhw_pkg::ERR_VOLUME;
            phase_next = abhw_pkg::PH_ERROR;
          end
        end else begin
          hw_next[1][sect[1:0]*8 +: 8] = b;
        end
        if (phase_next == abhw_pkg::PH_ARCH) begin
          if (sect >= 5'd13) begin
            phase_next = abhw_pkg::PH_PREFIX;
            sect_next = '0;
          end else sect_next = sect + 5'd1;
        end
      end
      abhw_pkg::PH_PREFIX: begin
        if (sect == 5'd0 && members >= member_limit) begin
          if (err_next == abhw_pkg::ERR_OK) err_next = abhw_pkg::ERR_COUNT;
          phase_next = abhw_pkg::PH_ERROR;
        end else begin
          if (sect == 5'd0) bstart_next = byte_pos;
          if (sect < 5'd6) begin
            logic [7:0] lead;
            lead = 8'h00;
            unique case (sect[2:0])
              3'd0: lead = 8'h42;
              3'd1: lead = 8'h4c;
              3'd2: lead = 8'h43;
              3'd3: lead = 8'h4b;
              3'd4: lead = 8'h00;
              3'd5: lead = 8'h02;
              default: lead = 8'h00;
            endcase
            if (b != lead) begin
              if (err_next == abhw_pkg::ERR_OK) err_next = abhw_pkg::ERR_BLOCK;
              phase_next = abhw_pkg::PH_ERROR;
            end
          end else if (sect < 5'd8) begin
            hw_next[2][(sect[1:0]-2'd2)*8 +: 8] = b;
          end else if (sect < 5'd12) begin
            hw_next[3][sect[1:0]*8 +: 8] = b;
            if (sect == 5'd11 && !abhw_pkg::flags_ok(hw_next[3])) begin
              if (err_next == abhw_pkg::ERR_OK) err_next = abhw_pkg::ERR_HEADER;
              phase_next = abhw_pkg::PH_ERROR;
            end
          end else if (sect < 5'd16) begin
            hw_next[4][sect[1:0]*8 +: 8] = b;
          end else begin
            if (b == 8'd0 || hw[2][15:0] != 16'd45 + {8'd0, b}) begin
              if (err_next == abhw_pkg::ERR_OK) err_next = abhw_pkg::ERR_HEADER;
              phase_next = abhw_pkg::PH_ERROR;
            end else begin
              name_next = b;
              phase_next = abhw_pkg::PH_NAME;
              sect_next = '0;
            end
          end
          if (phase_next == abhw_pkg::PH_PREFIX && sect < 5'd16) sect_next = sect + 5'd1;
        end
      end
      abhw_pkg::PH_NAME: begin
        if (b < 8'h20 || b > 8'h7e) begin
          if (err_next == abhw_pkg::ERR_OK) err_next = abhw_pkg::ERR_NAME;
          phase_next = abhw_pkg::PH_ERROR;
        end else begin
          if (name_left != 8'd0) name_next = name_left - 8'd1;
          if (name_next == 8'd0) begin
            phase_next = abhw_pkg::PH_TAIL;
            sect_next = '0;
          end
        end
      end
      abhw_pkg::PH_TAIL: begin
        if (sect < 5'd16) begin
          unique case (sect[3:2])
            2'd0: hw_next[5][sect[1:0]*8 +: 8] = b;
            2'd1: hw_next[6][sect[1:0]*8 +: 8] = b;
            2'd2: hw_next[7][sect[1:0]*8 +: 8] = b;
            default: hw_next[8][sect[1:0]*8 +: 8] = b;
          endcase
        end else if (sect >= 5'd24) begin
          hw_next[9][sect[1:0]*8 +: 8] = b;
        end
        if (sect < 5'd27) sect_next = sect + 5'd1;
        else begin
          fl = hw[3];
          dsz = hw[4];
          split = (fl & 32'h0a) != 32'd0;
          if ((!split && hw_next[6] != dsz)
              || (fl[4] && !split && hw_next[5] != dsz)) begin
            if (err_next == abhw_pkg::ERR_OK) err_next = abhw_pkg::ERR_SIZES;
            phase_next = abhw_pkg::PH_ERROR;
          end else begin
            members_next = members + 20'd1;
            push_a = 1'b1;
            if (crc_status == 2'd0 && !split && dsz != 32'd0 && dsz <= crc_size_limit) begin
              cst_next = 2'd1;
              crc_next = 32'hffff_ffff;
              exp_next = hw_next[9];
            end
            pay_next = dsz;
            sect_next = '0;
            phase_next = (dsz != 32'd0) ? abhw_pkg::PH_PAYLOAD : abhw_pkg::PH_PREFIX;
          end
        end
      end
      abhw_pkg::PH_PAYLOAD: begin
        if (crc_status == 2'd1) crc_next = abhw_pkg::crc_byte(crc, b);
        if (pay_left != 32'd0) pay_next = pay_left - 32'd1;
        if (pay_next == 32'd0) begin
          if (crc_status == 2'd1) begin
            if (crc_next != crc_exp) begin
              if (err_next == abhw_pkg::ERR_OK) err_next = abhw_pkg::ERR_CRC;
              phase_next = abhw_pkg::PH_ERROR;
            end else cst_next = 2'd2;
          end
          if (phase_next == abhw_pkg::PH_PAYLOAD) begin
            phase_next = abhw_pkg::PH_PREFIX;
            sect_next = '0;
          end
        end
      end
      default: ;
    endcase

    verr = err_next;
    if (verr == abhw_pkg::ERR_OK) begin
      if (!(phase_next == abhw_pkg::PH_PREFIX && sect_next == 5'd0)) verr = abhw_pkg::ERR_TRUNC;
      else if (members_next == 20'd0) verr = abhw_pkg::ERR_EMPTY;
    end
    push_b = s_axis_tlast;

    rec_a = '0;
    rec_a.record_kind = 1'b0;
    rec_a.position = block_start;
    rec_a.data_size = dsz;
    rec_a.member_flags = fl[7:0];
    rec_a.unpacked_size = hw_next[5];
    rec_a.attributes = hw_next[7];
    rec_a.dos_stamp = hw_next[8];
    rec_a.packed_crc = hw_next[9];
    rec_a.error_code = abhw_pkg::ERR_OK;
    rec_a.member_count = members_next;
    rec_a.volume_kind = abhw_pkg::vol_kind(hw_next[0]);
    rec_a.disk_number = hw_next[1][15:0];

    rec_b = '0;
    rec_b.record_kind = 1'b1;
    rec_b.position = pos_inc;
    rec_b.error_code = verr;
    rec_b.member_count = members_next;
    rec_b.volume_kind = abhw_pkg::vol_kind(hw_next[0]);
    rec_b.disk_number = hw_next[1][15:0];
  end

  always_ff @(posedge clk) begin
    if (rst || (in_fire && s_axis_tlast)) begin
      phase <= abhw_pkg::PH_ARCH;
      sect <= '0;
      byte_pos <= '0;
      for (int w = 0; w < 10; w++) hw[w] <= '0;
      name_left <= '0;
      pay_left <= '0;
      members <= '0;
      crc <= 32'hffff_ffff;
      crc_status <= '0;
      first_err <= '0;
      block_start <= '0;
      crc_exp <= '0;
    end else if (in_fire) begin
      phase <= phase_next;
      sect <= sect_next;
      byte_pos <= pos_inc;
      for (int w = 0; w < 10; w++) hw[w] <= hw_next[w];
      name_left <= name_next;
      pay_left <= pay_next;
      members <= members_next;
      crc <= crc_next;
      crc_status <= cst_next;
      first_err <= err_next;
      block_start <= bstart_next;
      crc_exp <= exp_next;
    end
  end

  abhw_out_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push_a (in_fire && push_a),
    .rec_a  (rec_a),
    .push_b (in_fire && push_b),
    .rec_b  (rec_b),
    .room   (room),
    .tvalid (m_axis_tvalid),
    .tready (m_axis_tready),
    .head   (head)
  );
endmodule
`default_nettype wire

### hw/rtl/abhw_out_queue.sv
`default_nettype none
// four-entry result queue: takes a member record plus verdict of one byte
module abhw_out_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_a,
  input  wire abhw_pkg::rec_t  rec_a,
  input  wire logic            push_b,
  input  wire abhw_pkg::rec_t  rec_b,
  output logic                 room,
  output logic                 tvalid,
  input  wire logic            tready,
  output abhw_pkg::rec_t       head
);
  abhw_pkg::rec_t slot [4];
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr;
  logic [2:0] fill;
  logic pop;
  logic [1:0] n_push;

  assign pop = tvalid && tready;
  assign tvalid = fill != 3'd0;
  assign head = slot[rd_ptr];
  assign n_push = {1'b0, push_a} + {1'b0, push_b};
  // accept only with room for two more after the current fill
  assign room = fill <= 3'd2;

  always_ff @(posedge clk) begin
    if (push_a) slot[wr_ptr] <= rec_a;
    if (push_b) slot[push_a ? wr_ptr + 2'd1 : wr_ptr] <= rec_b;
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {1'b0, n_push} - {2'd0, pop};
    end
  end
endmodule
`default_nettype wire

### hw/rtl/abhw_checker.sv
`default_nettype none
`include "archive_block_header_walker_assert.svh"
module abhw_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic m_axis_tuser
);
  // a waiting record stays offered, with its tuser unchanged, until taken
  `ABHW_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ABHW_ASSERT_NEXT(a_user_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tuser))
  // with the output drained, the input side is always open
  `ABHW_ASSERT_IMP(a_ready_empty, !m_axis_tvalid, s_axis_tready)
endmodule

bind archive_block_header_walker abhw_checker u_abhw_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
